// File: rtl/core/morphing_sawtooth_waveshaper_osc_defines.svh
// Assertion macros for the morphing sawtooth waveshaper oscillator.
// Used by rtl/core/morphing_sawtooth_waveshaper_osc.sv; expects clk and rst_n in scope.
`ifndef MORPHING_SAWTOOTH_WAVESHAPER_OSC_DEFINES_SVH
`define MORPHING_SAWTOOTH_WAVESHAPER_OSC_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define MSWO_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mswo assertion failed");
// Condition must never be true outside reset.
`define MSWO_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mswo forbidden condition seen");
`else
`define MSWO_ASSERT(lbl, prop)
`define MSWO_ASSERT_NEVER(lbl, cond)
`endif

`endif

// File: rtl/core/mswo_pkg.sv
// Package for the morphing sawtooth waveshaper oscillator: sequencer and
// region types, fixed-point constants and configuration register indexes. No dependencies.
package mswo_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FOLD,
        ST_GAIN,
        ST_CTHR,
        ST_AMP,
        ST_DONE
    } state_t;

    // Knob regions
    typedef enum logic [1:0] {
        RGN_LOW,
        RGN_MID,
        RGN_HIGH
    } region_t;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_LOW = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_HIGH = 8'd3;

    localparam logic [23:0] PHASE_INC_RST = 24'd0;
    localparam logic [15:0] AMPLITUDE_RST = 16'd16384;
    localparam logic [13:0] SPLIT_LOW_RST = 14'd6554;
    localparam logic [13:0] SPLIT_HIGH_RST = 14'd13107;

    localparam logic [14:0] ONE_Q14 = 15'd16384;
    localparam logic [29:0] CMP_OFFSET = 30'd3277;
    localparam logic signed [16:0] CMP_SCALE = 17'sd6554;

    // Restoring divider: 15-bit numerator shifted up by 14, one bit per step
    localparam logic [4:0] DIV_LAST = 5'd28;

    localparam logic signed [47:0] SAT_MAX = 48'sd32767;
    localparam logic signed [47:0] SAT_MIN = -48'sd32768;

endpackage

// File: rtl/core/morphing_sawtooth_waveshaper_osc.sv
// Each accepted knob beat runs through the one-bit-per-cycle restoring divider that finds
// the region fraction, then through the fold, gain, comparator-threshold and amplitude
// steps on the shared multiplier; no new knob beat is taken until its sample is loaded.
// A finished sample waits in the output register without holding the next divide.
// Reset (rst_n low, asynchronous): phase to zero, registers to their defaults,
// sequencer idle, output empty. Depends on mswo_pkg and the defines header.
`include "morphing_sawtooth_waveshaper_osc_defines.svh"

module morphing_sawtooth_waveshaper_osc (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mswo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mswo_pkg::CFG_DATA_W-1:0] cfg_data,
    // Knob input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [14:0] position, [15] zero pad
    // Sample output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata    // [15:0] sample (signed)
);
    import mswo_pkg::*;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    region_t                region_reg, region_next;
    logic [23:0]            phase_inc_reg, phase_inc_next;
    logic [15:0]            amplitude_reg, amplitude_next;
    logic [13:0]            split_low_reg, split_low_next;
    logic [13:0]            split_high_reg, split_high_next;
    logic [23:0]            phase_reg, phase_next;
    logic [4:0]             div_cnt_reg, div_cnt_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    // Datapath (no reset)
    logic [14:0]            rem_reg, rem_next;
    logic [14:0]            den_reg, den_next;
    logic [28:0]            quo_reg, quo_next;
    logic signed [14:0]     saw_reg, saw_next;
    logic signed [17:0]     rect_reg, rect_next;
    logic signed [16:0]     rgain_reg, rgain_next;
    logic signed [17:0]     mix_reg, mix_next;
    logic [15:0]            res_reg, res_next;
    logic [15:0]            m_tdata_reg, m_tdata_next;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic                   accept;
    logic [14:0]            pos;
    logic [15:0]            trial;
    logic                   trial_ge;

    // Shared signed multiplier
    logic signed [30:0]     mul_a;
    logic signed [16:0]     mul_b;
    logic signed [47:0]     prod;
    logic signed [47:0]     prod_sh14;
    logic signed [47:0]     prod_sh16;

    // Shaper parameters, decoded from the region and the quotient
    logic [14:0]            rect_t;
    logic [14:0]            rect_g;
    logic [28:0]            comp_t;
    logic [14:0]            comp_g;
    logic [15:0]            fold_sum;
    logic [13:0]            fold_offs;
    logic signed [18:0]     fold_base;
    logic signed [18:0]     fold_sum19;
    logic                   saw_gt;
    logic signed [17:0]     comp_val;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign pos       = s_tdata[14:0];

    // One divider step: shift in the next dividend bit, subtract when it fits
    assign trial    = {rem_reg, quo_reg[28]};
    assign trial_ge = (trial >= {1'b0, den_reg});

    assign prod      = mul_a * mul_b;
    assign prod_sh14 = prod >>> 14;
    assign prod_sh16 = prod >>> 16;

    // Region decode of the shaper thresholds and gains
    always_comb
    begin
        rect_t = ONE_Q14;
        rect_g = 15'd0;
        comp_t = 29'd0;
        comp_g = ONE_Q14;
        case (region_reg)
            RGN_LOW:
            begin
                rect_t = quo_reg[14:0];
                rect_g = ONE_Q14;
                comp_g = 15'd0;
            end
            RGN_MID:
            begin
                rect_g = ONE_Q14 - quo_reg[14:0];
                comp_g = quo_reg[14:0];
            end
            RGN_HIGH:
            begin
                comp_t = quo_reg;
            end
            default:
            begin
                rect_t = ONE_Q14;
            end
        endcase
    end

    // Fold terms; the offset is floor((1 - t) / 2) with t in [0, 1]
    assign fold_sum  = {1'b0, rect_t} + {1'b0, ONE_Q14};
    assign fold_offs = 14'((ONE_Q14 - rect_t) >> 1);
    assign fold_base = ($signed({saw_reg[14], saw_reg}) <= $signed({1'b0, rect_t}))
                     ? 19'(saw_reg)
                     : $signed(19'(rect_t)) - $signed(prod_sh14[18:0]);
    assign fold_sum19 = fold_base + $signed(19'(fold_offs));

    // Comparator: polarity flips in the top region
    assign saw_gt   = (48'(saw_reg) > prod_sh14);
    assign comp_val = (saw_gt ^ (region_reg == RGN_HIGH))
                    ? -$signed(18'(comp_g))
                    : $signed(18'(comp_g));

    // ------------------------------------------------------------------
    // Sequencer and datapath next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        region_next     = region_reg;
        phase_inc_next  = phase_inc_reg;
        amplitude_next  = amplitude_reg;
        split_low_next  = split_low_reg;
        split_high_next = split_high_reg;
        phase_next      = phase_reg;
        div_cnt_next    = div_cnt_reg;
        m_tvalid_next   = m_tvalid_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        quo_next        = quo_reg;
        saw_next        = saw_reg;
        rect_next       = rect_reg;
        rgain_next      = rgain_reg;
        mix_next        = mix_reg;
        res_next        = res_reg;
        m_tdata_next    = m_tdata_reg;
        mul_a           = '0;
        mul_b           = '0;

        // Register writes are to arrive only while the block is idle; the block does not enforce it
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PHASE_INC:  phase_inc_next  = cfg_data[23:0];
                CFG_AMPLITUDE:  amplitude_next  = cfg_data[15:0];
                CFG_SPLIT_LOW:  split_low_next  = cfg_data[13:0];
                CFG_SPLIT_HIGH: split_high_next = cfg_data[13:0];
                default: ;
            endcase
        end

        // Drop the sample beat once taken
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Advance the phase; the sawtooth is phase[23:9] - 1 in Q1.14
                    phase_next   = phase_reg + phase_inc_reg;
                    saw_next     = $signed({~phase_next[23], phase_next[22:9]});
                    rem_next     = 15'd0;
                    div_cnt_next = 5'd0;
                    if (pos < {1'b0, split_low_reg})
                    begin
                        region_next = RGN_LOW;
                        den_next    = {1'b0, split_low_reg};
                        quo_next    = {pos, 14'd0};
                    end
                    else if (pos < {1'b0, split_high_reg})
                    begin
                        region_next = RGN_MID;
                        den_next    = {1'b0, split_high_reg - split_low_reg};
                        quo_next    = {pos - {1'b0, split_low_reg}, 14'd0};
                    end
                    else
                    begin
                        region_next = RGN_HIGH;
                        den_next    = ONE_Q14 - {1'b0, split_high_reg};
                        quo_next    = {pos - {1'b0, split_high_reg}, 14'd0};
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next     = trial_ge ? 15'(trial - {1'b0, den_reg}) : trial[14:0];
                quo_next     = {quo_reg[27:0], trial_ge};
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == DIV_LAST)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                // Folding rectifier: t - floor((t + 1) * x) above the threshold
                mul_a      = $signed(31'(fold_sum));
                mul_b      = 17'(saw_reg);
                rect_next  = fold_sum19[17:0];
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                mul_a      = 31'(rect_reg);
                mul_b      = $signed(17'(rect_g));
                rgain_next = prod_sh14[16:0];
                state_next = ST_CTHR;
            end
            ST_CTHR:
            begin
                // Comparator threshold (c + 0.2) * 0.4, then sum with the gained fold
                mul_a      = $signed({1'b0, 30'(comp_t) + CMP_OFFSET});
                mul_b      = CMP_SCALE;
                mix_next   = 18'(rgain_reg) + comp_val;
                state_next = ST_AMP;
            end
            ST_AMP:
            begin
                mul_a = 31'(mix_reg);
                mul_b = $signed({1'b0, amplitude_reg});
                if (prod_sh16 > SAT_MAX)
                    res_next = SAT_MAX[15:0];
                else if (prod_sh16 < SAT_MIN)
                    res_next = SAT_MIN[15:0];
                else
                    res_next = prod_sh16[15:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            region_reg     <= RGN_LOW;
            phase_inc_reg  <= PHASE_INC_RST;
            amplitude_reg  <= AMPLITUDE_RST;
            split_low_reg  <= SPLIT_LOW_RST;
            split_high_reg <= SPLIT_HIGH_RST;
            phase_reg      <= 24'd0;
            div_cnt_reg    <= 5'd0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            region_reg     <= region_next;
            phase_inc_reg  <= phase_inc_next;
            amplitude_reg  <= amplitude_next;
            split_low_reg  <= split_low_next;
            split_high_reg <= split_high_next;
            phase_reg      <= phase_next;
            div_cnt_reg    <= div_cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        quo_reg     <= quo_next;
        saw_reg     <= saw_next;
        rect_reg    <= rect_next;
        rgain_reg   <= rgain_next;
        mix_reg     <= mix_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MSWO_ASSERT(a_accept_starts_div, accept |=> (state_reg == ST_DIV))
    `MSWO_ASSERT(a_rem_below_den, (state_reg == ST_DIV) |-> (rem_reg < den_reg))
    `MSWO_ASSERT(a_frac_below_one,
        ((state_reg == ST_FOLD) && (region_reg != RGN_HIGH)) |-> (quo_reg < 29'd16384))
    `MSWO_ASSERT(a_phase_moves_on_accept, !accept |=> $stable(phase_reg))
    `MSWO_ASSERT(a_done_loads_output,
        ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready))
            |=> (m_tvalid_reg && (state_reg == ST_IDLE)))
    `MSWO_ASSERT_NEVER(a_div_count_range,
        (state_reg == ST_DIV) && (div_cnt_reg > DIV_LAST))

endmodule

// File: bench/tb_morphing_sawtooth_waveshaper_osc.sv
// Self-checking bench for morphing_sawtooth_waveshaper_osc: knob beats in, sample beats out,
// each sample checked against a cycle-free fixed-point model of the oscillator kept here.
// Depends on mswo_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_morphing_sawtooth_waveshaper_osc;

    // Q2.14 constants of the shaper math, held signed so all sums stay signed
    localparam longint UNITY    = 16384;
    localparam longint CMP_BIAS = 3277;
    localparam longint CMP_GAIN = 6554;
    localparam int     KNOB_TOP = 19661;   // 1.2 in Q2.14
    localparam int     SETTLE_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [mswo_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mswo_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // [14:0] position, [15] zero pad

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [15:0] sample (signed)

    // Shadow copy of the block's registers and phase accumulator
    logic [23:0] inc_reg;
    logic [15:0] amp_reg;
    logic [13:0] lo_reg;
    logic [13:0] hi_reg;
    logic [23:0] osc_phase;

    logic [15:0] pending_samples[$];
    int          bad_beats = 0;
    bit          idle_bursts = 1'b1;
    int          rx_hold = 0;

    morphing_sawtooth_waveshaper_osc i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    function automatic void reset_model();
        inc_reg   = mswo_pkg::PHASE_INC_RST;
        amp_reg   = mswo_pkg::AMPLITUDE_RST;
        lo_reg    = mswo_pkg::SPLIT_LOW_RST;
        hi_reg    = mswo_pkg::SPLIT_HIGH_RST;
        osc_phase = '0;
    endfunction

    // Mirror one register write; unknown indexes fall through untouched
    function automatic void store_reg(logic [mswo_pkg::CFG_IDX_W-1:0] idx,
                                      logic [mswo_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            mswo_pkg::CFG_PHASE_INC:  inc_reg = data[23:0];
            mswo_pkg::CFG_AMPLITUDE:  amp_reg = data[15:0];
            mswo_pkg::CFG_SPLIT_LOW:  lo_reg  = data[13:0];
            mswo_pkg::CFG_SPLIT_HIGH: hi_reg  = data[13:0];
            default: ;
        endcase
    endfunction

    // Advance the phase by one tick and shape it into the next sample.
    // All shifts are >>> on signed longint, i.e. floor.
    function automatic logic [15:0] advance_and_shape(logic [14:0] pos);
        longint p, lo, hi, q;
        longint rect_t, rect_g, comp_t, comp_g;
        longint saw, rect, comp, cthr, mix, res;
        p  = longint'(pos);
        lo = longint'(lo_reg);
        hi = longint'(hi_reg);

        // Region: rectifier only, blend, or comparator only
        if (p < lo)
        begin
            rect_t = (p * UNITY) / lo;
            rect_g = UNITY;
            comp_t = 0;
            comp_g = 0;
        end
        else if (p < hi)
        begin
            q = ((p - lo) * UNITY) / (hi - lo);
            rect_t = UNITY;
            rect_g = UNITY - q;
            comp_t = 0;
            comp_g = q;
        end
        else
        begin
            q = ((p - hi) * UNITY) / (UNITY - hi);
            rect_t = UNITY;
            rect_g = 0;
            comp_t = q;
            comp_g = UNITY;
        end

        osc_phase = osc_phase + inc_reg;
        saw = longint'(osc_phase[23:9]) - UNITY;

        // Fold above the threshold, recenter, apply gain
        if (saw <= rect_t)
            rect = saw;
        else
            rect = rect_t - (((rect_t + UNITY) * saw) >>> 14);
        rect = rect + ((UNITY - rect_t) >>> 1);
        rect = (rect * rect_g) >>> 14;

        // Comparator polarity flips once the knob reaches split_high
        cthr = ((comp_t + CMP_BIAS) * CMP_GAIN) >>> 14;
        if (p < hi)
            comp = (saw > cthr) ? -UNITY : UNITY;
        else
            comp = (saw > cthr) ? UNITY : -UNITY;
        comp = (comp * comp_g) >>> 14;

        mix = rect + comp;
        res = (mix * longint'(amp_reg)) >>> 16;
        if (res > 32767)
            res = 32767;
        if (res < -32768)
            res = -32768;
        return res[15:0];
    endfunction

    // ------------------------------------------------------------------
    // Sample checker: every output beat pops the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        logic [15:0] want;
        if (m_tvalid && m_tready)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("sample beat with nothing pending: actual %0d", $signed(m_tdata));
                bad_beats++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (m_tdata !== want)
                begin
                    $error("sample mismatch: expected %0d, actual %0d",
                           $signed(want), $signed(m_tdata));
                    bad_beats++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample receiver: random stall bursts, plus a long hold on request
    // ------------------------------------------------------------------

    always
    begin
        @(posedge clk);
        if (rx_hold > 0)
        begin
            // Hold off long enough that the block backs up into its input
            m_tready <= 1'b0;
            repeat (rx_hold) @(posedge clk);
            rx_hold = 0;
        end
        else if (idle_bursts && $urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one knob beat; valid stays high afterwards so beats can run back to back
    task automatic send_knob(input logic [14:0] pos);
        if (idle_bursts && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pos};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_samples.push_back(advance_and_shape(pos));
    endtask

    // Drop valid, drain every pending sample, then let the pipeline go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register beat; drop valid only after the last of a group
    task automatic write_reg(input logic [mswo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mswo_pkg::CFG_DATA_W-1:0] data,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        store_reg(idx, data);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [23:0] inc, input logic [23:0] amp,
                                  input logic [23:0] lo, input logic [23:0] hi);
        settle();
        write_reg(mswo_pkg::CFG_PHASE_INC, inc, 1'b0);
        write_reg(mswo_pkg::CFG_AMPLITUDE, amp, 1'b0);
        write_reg(mswo_pkg::CFG_SPLIT_LOW, lo, 1'b0);
        write_reg(mswo_pkg::CFG_SPLIT_HIGH, hi, 1'b1);
    endtask

    // Mostly well-formed knob values, some hugging the split points, a few out of range
    function automatic logic [14:0] rand_position();
        int r;
        int v;
        r = $urandom_range(0, 19);
        if (r < 2)
        begin
            v = $urandom_range(0, 32767);
        end
        else if (r < 6)
        begin
            v = ((r & 1) ? int'(lo_reg) : int'(hi_reg)) + int'($urandom_range(0, 2)) - 1;
            if (v < 0)
                v = 0;
        end
        else
        begin
            v = $urandom_range(0, KNOB_TOP);
        end
        return v[14:0];
    endfunction

    // Pick a register set, leaning on the extremes and the odd split layouts
    task automatic random_settings();
        logic [23:0] inc;
        logic [15:0] amp;
        int lo;
        int hi;
        logic [23:0] amp_word;
        logic [23:0] lo_word;
        logic [23:0] hi_word;
        case ($urandom_range(0, 4))
            0: inc = 24'h000000;
            1: inc = 24'hFFFFFF;
            2: inc = 24'($urandom_range(1, 4096));
            default: inc = 24'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0: amp = 16'd0;
            1: amp = 16'd32768;
            2: amp = 16'($urandom);
            default: amp = 16'($urandom_range(0, 32768));
        endcase
        case ($urandom_range(0, 9))
            0:
            begin
                lo = 0;
                hi = $urandom_range(1, 16383);
            end
            1:
            begin
                lo = $urandom_range(2, 16383);
                hi = $urandom_range(1, lo);
            end
            2:
            begin
                lo = 1;
                hi = 2;
            end
            3:
            begin
                lo = 16382;
                hi = 16383;
            end
            default:
            begin
                lo = $urandom_range(1, 16382);
                hi = $urandom_range(lo + 1, 16383);
            end
        endcase
        amp_word = {8'd0, amp};
        lo_word  = {10'd0, 14'(lo)};
        hi_word  = {10'd0, 14'(hi)};
        // Junk in the unused upper bits must be dropped by the block
        if ($urandom_range(0, 3) == 0)
        begin
            amp_word[23:16] = 8'($urandom);
            lo_word[23:14]  = 10'($urandom);
            hi_word[23:14]  = 10'($urandom);
        end
        apply_settings(inc, amp_word, lo_word, hi_word);
        if ($urandom_range(0, 5) == 0)
        begin
            // Let valid drop between the last settings write and the stray write
            @(posedge clk);
            write_reg(8'($urandom_range(4, 255)), 24'($urandom), 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: zero increment pins the sawtooth at -1; walk the knob across the splits
    task automatic test_reset_defaults();
        logic [14:0] knobs[8];
        knobs = '{15'd0, 15'd6553, 15'd6554, 15'd13106,
                  15'd13107, 15'd16384, 15'd19661, 15'd32767};
        foreach (knobs[k])
            send_knob(knobs[k]);
    endtask

    task automatic test_special_cases();
        // Narrowest splits with full-step phase and amplitude 32768
        apply_settings(24'hFFFFFF, 24'd32768, 24'd1, 24'd2);
        send_knob(15'd0);
        send_knob(15'd1);
        send_knob(15'd2);
        send_knob(15'd19661);
        // Split_low zero skips the first region; amplitude at the top of its 16-bit range
        apply_settings(24'h123457, 24'd65535, 24'd0, 24'd16383);
        send_knob(15'd0);
        send_knob(15'd8000);
        send_knob(15'd16383);
        send_knob(15'd32767);
        // Split_high under split_low leaves the blend region empty
        apply_settings(24'h800000, 24'd20000, 24'd9000, 24'd5000);
        send_knob(15'd4999);
        send_knob(15'd8999);
        send_knob(15'd9000);
        send_knob(15'd12000);
        // Writes to unknown indexes must change nothing
        settle();
        write_reg(8'd4, 24'hFFFFFF, 1'b0);
        write_reg(8'hFF, 24'hFFFFFF, 1'b1);
        send_knob(15'd16384);
        apply_settings(24'h0ABCDE, 24'd0, 24'd4000, 24'd12000);
        send_knob(15'd16384);
    endtask

    // Receiver stalls for a long stretch while knob beats keep coming
    task automatic test_backpressure();
        settle();
        rx_hold = 400;
        repeat (12)
            send_knob(rand_position());
    endtask

    // Sender waits for every pending sample before going on
    task automatic test_sender_pause();
        repeat (8)
            send_knob(rand_position());
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (8)
            send_knob(rand_position());
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        repeat (phases)
        begin
            random_settings();
            repeat (per_phase)
                send_knob(rand_position());
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        reset_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_special_cases();
        test_random_phases(7, 100);
        test_backpressure();
        test_sender_pause();
        test_random_phases(8, 100);

        // Last stretch runs with no idling on either side
        settle();
        idle_bursts = 1'b0;
        test_random_phases(2, 100);

        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (bad_beats == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/mswo_pkg.sv
rtl/core/morphing_sawtooth_waveshaper_osc.sv
bench/tb_morphing_sawtooth_waveshaper_osc.sv
